// File: rtl/gcl_pkg.sv
// gcl_pkg: shared types and constants for the gcd / lcm unit.
// Used by gcl_gcd, gcl_div and gcd_lcm_unit; depends on nothing.

package gcl_pkg;

	// Fixed field widths of the request and result
	localparam int FIELD_WIDTH  = 32;
	localparam int RESULT_WIDTH = 64;

	// Operation codes carried on kind
	localparam logic KIND_GCD = 1'b0;
	localparam logic KIND_LCM = 1'b1;

	// Status of an iterative arithmetic unit toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

// File: rtl/gcl_gcd.sv
// gcl_gcd: iterative binary gcd of two unsigned magnitudes.
// One shared subtract/shift step per cycle. Depends on gcl_pkg.

module gcl_gcd #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         mag_a,
	input  logic [W-1:0]         mag_b,
	output gcl_pkg::unit_status_t status,
	output logic [W-1:0]         gcd_value
);

	localparam int KW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  g_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    diff_xy;
	logic [W:0]    diff_yx;

	// Shared difference unit: both orders, borrow picks the larger side
	assign diff_xy = {1'b0, x_q} - {1'b0, y_q};
	assign diff_yx = {1'b0, y_q} - {1'b0, x_q};

	// Step the reduction: strip common twos, strip single twos, subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= mag_a;
				y_q    <= mag_b;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (x_q == '0) begin
					g_q    <= y_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (y_q == '0) begin
					g_q    <= x_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (!diff_xy[W]) begin
					x_q <= diff_xy[W:1];
				end else begin
					y_q <= diff_yx[W:1];
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign gcd_value   = g_q;

endmodule

// File: rtl/gcl_div.sv
// gcl_div: restoring unsigned divider, one quotient bit per cycle.
// Divisor must be nonzero. Depends on gcl_pkg.

module gcl_div #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         dividend,
	input  logic [W-1:0]         divisor,
	output gcl_pkg::unit_status_t status,
	output logic [W-1:0]         quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	// Shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// Iterate W times, restoring on borrow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				den_q  <= divisor;
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], ~trial[W]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// File: rtl/gcd_lcm_unit.sv
// gcd_lcm_unit: top level, sequencer around the gcd and divider units.
// Depends on gcl_pkg, gcl_gcd and gcl_div.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------
//  request | in_valid, in_stall | kind, operand_a, operand_b
//  result  | out_valid,out_stall| result_value
//
// A request runs through the binary gcd unit; for lcm the sequencer then
// runs the divider and a multiply state. The result is then loaded into the
// output register, which out_stall can hold off.
// Reset clears the sequencer and the valid flags; no clearing pass.
// in_stall is high while a request is in work; a finished result waits in
// the output register under out_stall while the next request is taken.

module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic signed [gcl_pkg::FIELD_WIDTH-1:0] operand_a,
	input  logic signed [gcl_pkg::FIELD_WIDTH-1:0] operand_b,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [gcl_pkg::RESULT_WIDTH-1:0] result_value
);

	localparam int W  = OPERAND_WIDTH;
	localparam int RW = gcl_pkg::RESULT_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]            state_q;
	logic                  kind_q;
	logic                  neg_res_q;
	logic [W-1:0]          mb_q;
	logic [W-1:0]          ma_q;
	logic [RW-1:0]         res_q;
	logic                  out_valid_q;
	logic [RW-1:0]         out_value_q;

	logic [W-1:0]          a_low;
	logic [W-1:0]          b_low;
	logic [W-1:0]          mag_a;
	logic [W-1:0]          mag_b;
	logic                  accept;
	logic                  div_start;
	logic                  out_free;
	logic [W-1:0]          gcd_value;
	logic [W-1:0]          quotient;
	gcl_pkg::unit_status_t gcd_st;
	gcl_pkg::unit_status_t div_st;

	// Take the low W bits as two's complement and form magnitudes
	assign a_low = operand_a[W-1:0];
	assign b_low = operand_b[W-1:0];
	assign mag_a = a_low[W-1] ? (~a_low + 1'b1) : a_low;
	assign mag_b = b_low[W-1] ? (~b_low + 1'b1) : b_low;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == ST_GCD) && gcd_st.done && (kind_q == gcl_pkg::KIND_LCM)
		&& (ma_q != '0) && (mb_q != '0);

	gcl_gcd #(.W(W)) u_gcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.mag_a     (mag_a),
		.mag_b     (mag_b),
		.status    (gcd_st),
		.gcd_value (gcd_value)
	);

	gcl_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ma_q),
		.divisor  (gcd_value),
		.status   (div_st),
		.quotient (quotient)
	);

	// Sequence: gcd, then for lcm divide and multiply (zero if an operand is zero), then load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q    <= kind;
						ma_q      <= mag_a;
						mb_q      <= mag_b;
						neg_res_q <= (kind == gcl_pkg::KIND_LCM) && (a_low[W-1] != b_low[W-1]);
						state_q   <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_st.done) begin
						if (kind_q == gcl_pkg::KIND_GCD) begin
							res_q   <= RW'(gcd_value);
							state_q <= ST_FIN;
						end else if (div_start) begin
							state_q <= ST_DIV;
						end else begin
							// lcm with a zero operand
							res_q     <= '0;
							neg_res_q <= 1'b0;
							state_q   <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					res_q   <= RW'(quotient) * RW'(mb_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: load when free, hold under stall, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
				out_value_q <= neg_res_q ? (~res_q + 1'b1) : res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;

	// The gcd unit reports done only while the sequencer waits for it
	a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_st.done |-> (state_q == ST_GCD))
		else $error("gcd done outside gcd phase");

	// The gcd unit stays busy or finishes while the sequencer waits
	a_gcd_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (gcd_st.busy || gcd_st.done))
		else $error("gcd phase with idle gcd unit");

	// The divider only runs with a nonzero divisor and stays busy or finishes in its phase
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ((gcd_value != '0) && (div_st.busy || div_st.done)))
		else $error("divider phase with zero divisor or idle divider");

	// A gcd result is never negated
	a_gcd_sign: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (kind_q == gcl_pkg::KIND_GCD)) |-> !neg_res_q)
		else $error("gcd result marked negative");

endmodule

// File: dv/gcd_lcm_unit_tb.sv
// gcd_lcm_unit_tb: self-checking testbench for the gcd / lcm unit.
// Depends on gcl_pkg and gcd_lcm_unit; a built-in predictor checks every result.

module gcd_lcm_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OPW = 32;
	localparam int W   = gcl_pkg::FIELD_WIDTH;
	localparam int RW  = gcl_pkg::RESULT_WIDTH;

	localparam logic [W-1:0] MAX_OP = 32'h7fffffff;
	localparam logic [W-1:0] MIN_OP = 32'h80000000;

	// Drain wait before closing, sized from the lcm request time plus a margin
	localparam int DRAIN_CYCLES = 3 * OPW + 4 + 200;

	typedef struct {
		logic         kind;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} gcl_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = gcl_pkg::KIND_GCD;
	logic signed [W-1:0]  operand_a = '0;
	logic signed [W-1:0]  operand_b = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [RW-1:0] result_value;

	gcl_req_t      pending_reqs[$];
	logic [RW-1:0] expected_results[$];
	gcl_req_t      held_req;
	logic [RW-1:0] want_value;

	int send_idle_pct = 31;
	int recv_idle_pct = 86;
	int error_count = 0;
	int results_checked = 0;
	int gcd_accepted = 0;
	int lcm_accepted = 0;

	// Directed operand pairs: zeros, units, extremes, coprime near-max, mixed signs
	logic [W-1:0] dir_a[12] = '{32'h0, 32'h0, 32'hfffffff9, 32'h1, 32'hffffffff,
		MAX_OP, MIN_OP, MIN_OP, MIN_OP, MAX_OP, 32'd12, MIN_OP};
	logic [W-1:0] dir_b[12] = '{32'h0, 32'd7, 32'h0, 32'h1, 32'hffffffff,
		MAX_OP, MIN_OP, MAX_OP, 32'hffffffff, 32'h80000002, 32'hffffffee, 32'hfffffffa};

	gcd_lcm_unit #(
		.OPERAND_WIDTH(OPW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Magnitude and sign of an operand read as OPW-bit two's complement
	function automatic logic [63:0] operand_magnitude(input logic [W-1:0] field,
			output logic neg);
		logic [63:0] mask;
		logic [63:0] v;
		mask = (64'd1 << OPW) - 64'd1;
		v = 64'(field) & mask;
		neg = v[OPW-1];
		return neg ? (((~v) + 64'd1) & mask) : v;
	endfunction

	// Expected gcd, or signed lcm, of one request
	function automatic logic [RW-1:0] gcd_lcm_of(input gcl_req_t r);
		logic        neg_a;
		logic        neg_b;
		logic [63:0] mag_a;
		logic [63:0] mag_b;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] rem;
		logic [63:0] prod;
		mag_a = operand_magnitude(r.a, neg_a);
		mag_b = operand_magnitude(r.b, neg_b);
		x = mag_a;
		y = mag_b;
		while (y != 64'd0) begin
			rem = x % y;
			x = y;
			y = rem;
		end
		if (r.kind == gcl_pkg::KIND_GCD)
			return x;
		if (mag_a == 64'd0 || mag_b == 64'd0)
			return '0;
		prod = (mag_a / x) * mag_b;
		return (neg_a != neg_b) ? (64'd0 - prod) : prod;
	endfunction

	function automatic logic [W-1:0] special_operand();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h1;
			2: return 32'hffffffff;
			3: return MAX_OP;
			4: return MIN_OP;
			default: return 32'h1 << $urandom_range(0, 31);
		endcase
	endfunction

	// Random request; many shapes give the operands common factors
	function automatic gcl_req_t random_req();
		gcl_req_t     r;
		logic [W-1:0] f;
		logic [W-1:0] t;
		r.kind = $urandom_range(0, 1) ? gcl_pkg::KIND_LCM : gcl_pkg::KIND_GCD;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				r.a = $urandom;
				r.b = $urandom;
			end
			3: begin
				f = $urandom_range(1, 65535);
				r.a = f * $urandom_range(0, 32767);
				r.b = f * $urandom_range(0, 32767);
			end
			4: begin
				r.a = $urandom << $urandom_range(0, 31);
				r.b = $urandom << $urandom_range(0, 31);
			end
			5: begin
				r.a = special_operand();
				r.b = $urandom;
			end
			6: begin
				r.a = $urandom_range(0, 200) - 100;
				r.b = $urandom_range(0, 200) - 100;
			end
			7: begin
				r.a = $urandom;
				r.b = $urandom_range(0, 1) ? r.a : -r.a;
			end
			8: begin
				r.b = $urandom_range(1, 1000);
				r.a = r.b * $urandom_range(0, 2000000);
			end
			default: begin
				r.a = special_operand();
				r.b = special_operand();
			end
		endcase
		// Flip signs and order at random
		if ($urandom_range(0, 1))
			r.a = -r.a;
		if ($urandom_range(0, 1))
			r.b = -r.b;
		if ($urandom_range(0, 1)) begin
			t = r.a;
			r.a = r.b;
			r.b = t;
		end
		return r;
	endfunction

	task automatic load_random(input int n);
		repeat (n) pending_reqs.push_back(random_req());
	endtask

	task automatic flag_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// Hold until every request has gone in and every result has come out
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// Request driver: record accepted requests, then present the next or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			kind      <= gcl_pkg::KIND_GCD;
			operand_a <= '0;
			operand_b <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(gcd_lcm_of(held_req));
				if (held_req.kind == gcl_pkg::KIND_GCD)
					gcd_accepted++;
				else
					lcm_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					held_req = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					kind      <= held_req.kind;
					operand_a <= held_req.a;
					operand_b <= held_req.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest expectation, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					flag_error($sformatf("result %0d (0x%h) with no request outstanding",
						result_value, result_value));
				end else begin
					want_value = expected_results.pop_front();
					if (result_value !== want_value)
						flag_error($sformatf("result_value exp %0d (0x%h) got %0d (0x%h)",
							$signed(want_value), want_value, result_value, result_value));
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Sequence: reset, directed requests, then random ones in two idling phases and a back-to-back phase
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 12; i++) begin
			pending_reqs.push_back('{gcl_pkg::KIND_GCD, dir_a[i], dir_b[i]});
			pending_reqs.push_back('{gcl_pkg::KIND_LCM, dir_a[i], dir_b[i]});
		end
		load_random(333);
		wait_drained();

		send_idle_pct <= 86;
		recv_idle_pct <= 31;
		load_random(333);
		wait_drained();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		load_random(334);
		wait_drained();

		// Let any stray result show up before closing
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d gcd and %0d lcm requests, directed and random,",
			results_checked, gcd_accepted, lcm_accepted);
		$display("under sender-idle, receiver-idle and back-to-back traffic; %0d errors.",
			error_count);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Timeout with %0d requests pending and %0d results outstanding",
			pending_reqs.size(), expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/gcl_pkg.sv
rtl/gcl_gcd.sv
rtl/gcl_div.sv
rtl/gcd_lcm_unit.sv
dv/gcd_lcm_unit_tb.sv
